FILE: src/multi_channel_wait_timer_bank_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wait timer bank
// Shared concurrent assertion forms used by the controller and the datapath.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_WAIT_TIMER_BANK_ASSERT_SVH
`define MULTI_CHANNEL_WAIT_TIMER_BANK_ASSERT_SVH

// same-cycle implication
`define MCWTB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MCWTB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mcwtb_pkg.sv
// ----------------------------------------------------------------------------
// mcwtb_pkg
// Types, codes and defaults shared by the wait timer bank modules.
// ----------------------------------------------------------------------------
package mcwtb_pkg;

    localparam int NUM_SLOTS_DEF    = 16;
    localparam int MAX_WAITERS_DEF  = 15;
    localparam int PERIOD_WIDTH_DEF = 32;

    localparam int REQ_W       = 2;
    localparam int IN_TDATA_W  = 40;   // slot 4, period 32, repeat 1, pad
    localparam int OUT_TDATA_W = 16;   // status 2, blocked 1, slot 4, released 4, pad
    localparam int MASK_W      = 16;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_SET    = 2'd1,
        REQ_CANCEL = 2'd2,
        REQ_WAIT   = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_BAD_PERIOD = 2'd1,
        STAT_FULL       = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REQ_EX,
        S_SCAN_RD,
        S_SCAN_EX,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic accept;     // capture request, read slot stores
        logic req_ex;     // execute set/cancel/wait, push result
        logic rd_scan;    // read stores of the scan slot
        logic scan_ex;    // update scan slot, advance
        logic scan_skip;  // inactive slot, advance
        logic flush;      // push final tick result
    } t_cmd;

    typedef struct packed {
        logic in_is_tick;
        logic out_free;
        logic scan_active;
        logic scan_last;
        logic expire;
        logic pend_valid;
    } t_stat;

endpackage

FILE: src/mcwtb_ctrl.sv
// ----------------------------------------------------------------------------
// mcwtb_ctrl
// Sequencer: takes one request at a time, walks the slots on a tick.
// ----------------------------------------------------------------------------
`include "multi_channel_wait_timer_bank_assert.svh"

module mcwtb_ctrl
    import mcwtb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_stall;

    // a second expiry needs the output register to take the held one
    assign w_stall = i_stat.expire && i_stat.pend_valid && !i_stat.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.in_is_tick ? S_SCAN_RD : S_REQ_EX;
                end
            end
            S_REQ_EX: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN_RD: begin
                if (i_stat.scan_active) begin
                    n_state = S_SCAN_EX;
                end else if (i_stat.scan_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_SCAN_EX: begin
                if (!w_stall) begin
                    n_state = i_stat.scan_last ? S_FLUSH : S_SCAN_RD;
                end
            end
            S_FLUSH: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_REQ_EX:  o_cmd.req_ex = i_stat.out_free;
            S_SCAN_RD: begin
                o_cmd.rd_scan   = i_stat.scan_active;
                o_cmd.scan_skip = !i_stat.scan_active;
            end
            S_SCAN_EX: o_cmd.scan_ex = !w_stall;
            S_FLUSH:   o_cmd.flush = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

    `MCWTB_ASSERT_NEXT(a_scan_ex_leaves, i_clk, i_rst_n, r_state == S_SCAN_EX && !w_stall, r_state != S_SCAN_EX, "scan step did not advance")
    `MCWTB_ASSERT_NEXT(a_flush_holds, i_clk, i_rst_n, r_state == S_FLUSH && !i_stat.out_free, r_state == S_FLUSH, "flush left with output busy")
    `MCWTB_ASSERT_NEXT(a_req_done, i_clk, i_rst_n, r_state == S_REQ_EX && i_stat.out_free, r_state == S_IDLE, "request did not complete")

endmodule

FILE: src/mcwtb_datapath.sv
// ----------------------------------------------------------------------------
// mcwtb_datapath
// Slot stores, flags, expiry arithmetic, pending expiry and output register.
// ----------------------------------------------------------------------------
`include "multi_channel_wait_timer_bank_assert.svh"

module mcwtb_datapath
    import mcwtb_pkg::*;
#(
    parameter int NUM_SLOTS    = NUM_SLOTS_DEF,
    parameter int MAX_WAITERS  = MAX_WAITERS_DEF,
    parameter int PERIOD_WIDTH = PERIOD_WIDTH_DEF
)(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [REQ_W-1:0]       i_s_axis_tuser,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tuser,
    output logic                   o_m_axis_tlast,
    input  logic                   i_cfg_wr_en,
    input  logic [MASK_W-1:0]      i_cfg_wr_data,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int WC_W   = $clog2(MAX_WAITERS + 1);
    localparam logic [6:0]      NSLOT_V = 7'(NUM_SLOTS);
    localparam logic [WC_W-1:0] MAXW_V  = WC_W'(MAX_WAITERS);

    // request registers
    t_req_type               r_req;
    logic [3:0]              r_slot;
    logic [PERIOD_WIDTH-1:0] r_period;
    logic                    r_repeat;

    logic [MASK_W-1:0]       r_mask;

    // slot stores
    logic [PERIOD_WIDTH-1:0] r_period_mem [NUM_SLOTS];
    logic [PERIOD_WIDTH-1:0] r_elapsed_mem [NUM_SLOTS];
    logic [WC_W-1:0]         r_waiter_mem [NUM_SLOTS];
    logic [PERIOD_WIDTH-1:0] r_per_rd;
    logic [PERIOD_WIDTH-1:0] r_ela_rd;
    logic [WC_W-1:0]         r_wc_rd;
    logic                    r_wv_rd;

    logic [NUM_SLOTS-1:0]    r_active;
    logic [NUM_SLOTS-1:0]    r_periodic;
    logic [NUM_SLOTS-1:0]    r_signaled;
    logic [NUM_SLOTS-1:0]    r_wvalid;   // waiter count entry written since last release

    logic [SLOT_W-1:0]       r_cnt;
    logic                    r_pend_valid;
    logic [3:0]              r_pend_slot;
    logic [3:0]              r_pend_rel;

    logic                    r_out_valid;
    t_status                 r_out_status;
    logic                    r_out_blocked;
    logic                    r_out_expired;
    logic [3:0]              r_out_slot;
    logic [3:0]              r_out_rel;
    logic                    r_out_last;

    logic [SLOT_W-1:0]       w_slot_a;
    logic [SLOT_W-1:0]       w_rd_addr;
    logic                    w_slot_ok;
    logic                    w_period_zero;
    logic [WC_W-1:0]         w_wc;
    logic                    w_full;
    logic                    w_sig;
    logic                    w_set_wr;
    logic                    w_cancel;
    logic                    w_wait_inc;
    logic                    w_wait_ok;
    logic [PERIOD_WIDTH-1:0] w_ela_inc;
    logic                    w_expire;
    logic                    w_manual;
    logic                    w_ela_we;
    logic [SLOT_W-1:0]       w_ela_addr;
    logic [PERIOD_WIDTH-1:0] w_ela_data;
    logic                    w_out_free;
    logic                    w_push;
    logic                    w_push_scan;
    logic                    w_scan_exp;
    t_status                 w_req_status;

    assign w_slot_a      = SLOT_W'(r_slot);
    assign w_slot_ok     = {3'd0, r_slot} < NSLOT_V;
    assign w_period_zero = (r_period == '0);
    assign w_rd_addr     = i_cmd.accept ? SLOT_W'(i_s_axis_tdata[3:0]) : r_cnt;

    assign w_wc      = r_wv_rd ? r_wc_rd : '0;
    assign w_full    = (w_wc >= MAXW_V);
    assign w_sig     = r_signaled[w_slot_a];
    assign w_wait_ok = (r_req == REQ_WAIT) && w_slot_ok && !w_sig;

    assign w_set_wr   = i_cmd.req_ex && (r_req == REQ_SET) && w_slot_ok && !w_period_zero;
    assign w_cancel   = i_cmd.req_ex && (r_req == REQ_CANCEL) && w_slot_ok;
    assign w_wait_inc = i_cmd.req_ex && w_wait_ok && !w_full;

    always_comb begin
        if ((r_req == REQ_SET) && w_period_zero) begin
            w_req_status = STAT_BAD_PERIOD;
        end else if (w_wait_ok && w_full) begin
            w_req_status = STAT_FULL;
        end else begin
            w_req_status = STAT_OK;
        end
    end

    // elapsed count saturates at all ones
    assign w_ela_inc  = (r_ela_rd == '1) ? r_ela_rd : r_ela_rd + 1'b1;
    assign w_expire   = (w_ela_inc >= r_per_rd);
    assign w_manual   = (7'(r_cnt) < 7'd16) && r_mask[4'(r_cnt)];
    assign w_scan_exp = i_cmd.scan_ex && w_expire;

    assign w_ela_we   = w_set_wr || i_cmd.scan_ex;
    assign w_ela_addr = w_set_wr ? w_slot_a : r_cnt;
    assign w_ela_data = (w_set_wr || (w_expire && r_periodic[r_cnt])) ? '0 : w_ela_inc;

    assign w_out_free  = !r_out_valid || i_m_axis_tready;
    assign w_push_scan = w_scan_exp && r_pend_valid;
    assign w_push      = i_cmd.req_ex || i_cmd.flush || w_push_scan;

    always_ff @(posedge i_clk) begin
        if (w_set_wr) begin
            r_period_mem[w_slot_a] <= r_period;
        end
        if (w_ela_we) begin
            r_elapsed_mem[w_ela_addr] <= w_ela_data;
        end
        if (w_wait_inc) begin
            r_waiter_mem[w_slot_a] <= w_wc + 1'b1;
        end
        if (i_cmd.accept || i_cmd.rd_scan) begin
            r_per_rd <= r_period_mem[w_rd_addr];
            r_ela_rd <= r_elapsed_mem[w_rd_addr];
            r_wc_rd  <= r_waiter_mem[w_rd_addr];
            r_wv_rd  <= r_wvalid[w_rd_addr];
        end
    end

    // request capture and payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req    <= t_req_type'(i_s_axis_tuser);
            r_slot   <= i_s_axis_tdata[3:0];
            r_period <= PERIOD_WIDTH'(i_s_axis_tdata[35:4]);
            r_repeat <= i_s_axis_tdata[36];
        end
        if (w_scan_exp) begin
            r_pend_slot <= 4'(r_cnt);
            r_pend_rel  <= 4'(w_wc);
        end
        if (w_push && i_cmd.req_ex) begin
            r_out_status  <= w_req_status;
            r_out_blocked <= w_wait_ok && !w_full;
            r_out_expired <= 1'b0;
            r_out_slot    <= '0;
            r_out_rel     <= '0;
            r_out_last    <= 1'b1;
        end else if (w_push) begin
            r_out_status  <= STAT_OK;
            r_out_blocked <= 1'b0;
            r_out_expired <= r_pend_valid;
            r_out_slot    <= r_pend_valid ? r_pend_slot : 4'd0;
            r_out_rel     <= r_pend_valid ? r_pend_rel : 4'd0;
            r_out_last    <= i_cmd.flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask       <= '0;
            r_active     <= '0;
            r_periodic   <= '0;
            r_signaled   <= '0;
            r_wvalid     <= '0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mask <= i_cfg_wr_data;
            end
            if (w_set_wr) begin
                r_active[w_slot_a]   <= 1'b1;
                r_periodic[w_slot_a] <= r_repeat;
                r_signaled[w_slot_a] <= 1'b0;
            end
            if (w_cancel) begin
                r_active[w_slot_a] <= 1'b0;
            end
            if (w_wait_inc) begin
                r_wvalid[w_slot_a] <= 1'b1;
            end
            if (w_scan_exp) begin
                r_wvalid[r_cnt] <= 1'b0;
                if (w_manual) begin
                    r_signaled[r_cnt] <= 1'b1;
                end
                if (!r_periodic[r_cnt]) begin
                    r_active[r_cnt] <= 1'b0;
                end
            end
            if (i_cmd.accept) begin
                r_cnt        <= '0;
                r_pend_valid <= 1'b0;
            end else begin
                if (i_cmd.scan_ex || i_cmd.scan_skip) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (w_scan_exp) begin
                    r_pend_valid <= 1'b1;
                end
            end
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_rel, r_out_slot, r_out_blocked, r_out_status};
    assign o_m_axis_tuser  = r_out_expired;
    assign o_m_axis_tlast  = r_out_last;

    assign o_stat.in_is_tick  = (t_req_type'(i_s_axis_tuser) == REQ_TICK);
    assign o_stat.out_free    = w_out_free;
    assign o_stat.scan_active = r_active[r_cnt];
    assign o_stat.scan_last   = (r_cnt == SLOT_W'(NUM_SLOTS - 1));
    assign o_stat.expire      = w_expire;
    assign o_stat.pend_valid  = r_pend_valid;

    `MCWTB_ASSERT_IMPL(a_push_free, i_clk, i_rst_n, w_push, w_out_free, "result pushed over a held result")
    `MCWTB_ASSERT_IMPL(a_non_expiry_last, i_clk, i_rst_n, r_out_valid && !r_out_expired, r_out_last, "non-expiry result not marked last")
    `MCWTB_ASSERT_NEXT(a_oneshot_stops, i_clk, i_rst_n, w_scan_exp && !r_periodic[r_cnt], !r_active[$past(r_cnt)], "one-shot slot still active after expiry")

endmodule

FILE: src/multi_channel_wait_timer_bank.sv
// ----------------------------------------------------------------------------
// multi_channel_wait_timer_bank
// Bank of one-shot/periodic wait timers driven by tick, set, cancel and wait
// requests, reporting expiries in ascending slot order.
// ----------------------------------------------------------------------------
//   channel  | dir | tdata (low bit up)                           | tuser    | tlast
//   s_axis   | in  | slot_index, period_ticks, repeat_mode        | req_type | -
//   m_axis   | out | status, blocked, expired_slot, waiters_rel.  | expired  | last
//   cfg      | in  | manual_reset_mask (write enable + data)      | -        | -
//
// Set, cancel, wait: accept captures the request and reads its slot stores; the result
// is registered in the execute state once m_axis is free. Tick: the walk takes one slot
// at a time, reads an active slot's period/elapsed/waiter stores, skips inactive ones.
// Reset (synchronous, active low) clears flags, mask and control; no sweep.
// A result waiting on m_axis holds the walk only when a further result is due.
// ----------------------------------------------------------------------------
module multi_channel_wait_timer_bank
    import mcwtb_pkg::*;
#(
    parameter int NUM_SLOTS    = NUM_SLOTS_DEF,
    parameter int MAX_WAITERS  = MAX_WAITERS_DEF,
    parameter int PERIOD_WIDTH = PERIOD_WIDTH_DEF
)(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // slot_index, period_ticks, repeat_mode
    input  logic [REQ_W-1:0]       i_s_axis_tuser,   // req_type
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // status, blocked, expired_slot, waiters_released
    output logic                   o_m_axis_tuser,   // expired
    output logic                   o_m_axis_tlast,
    input  logic                   i_cfg_wr_en,
    input  logic [MASK_W-1:0]      i_cfg_wr_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    mcwtb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mcwtb_datapath #(
        .NUM_SLOTS    (NUM_SLOTS),
        .MAX_WAITERS  (MAX_WAITERS),
        .PERIOD_WIDTH (PERIOD_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat)
    );

endmodule
